// File: rtl/flptw_pkg.sv
// Shared types and constants for the four-level page table walker.
`default_nettype none

package flptw_pkg;

   localparam int unsigned FRAME_TOP_BIT = 36;
   localparam int unsigned ADDR_W        = 52;
   localparam int unsigned VA_W          = 48;
   localparam int unsigned ENTRY_W       = 64;

   localparam logic [ENTRY_W-1:0] FRAME_MASK =
      ((ENTRY_W'(1) << FRAME_TOP_BIT) - ENTRY_W'(1)) & ~ENTRY_W'(64'hFFF);
   localparam logic [ENTRY_W-1:0] FRAME_2M_MASK = FRAME_MASK & ~ENTRY_W'(64'h1F_FFFF);

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_ENTRY = 1'b1;

   localparam logic KIND_READ   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   localparam logic [1:0] LEVEL_PML4 = 2'd3;
   localparam logic [1:0] LEVEL_PDPT = 2'd2;
   localparam logic [1:0] LEVEL_PD   = 2'd1;
   localparam logic [1:0] LEVEL_PT   = 2'd0;

   localparam int unsigned PRESENT_BIT = 0;
   localparam int unsigned PS_BIT      = 7;

   typedef struct packed {
      logic                mode;
      logic [ADDR_W-1:0]   table_root;
      logic [VA_W-1:0]     vaddr;
      logic [ENTRY_W-1:0]  read_data;
   } req_type;

   typedef struct packed {
      logic                result_kind;
      logic [ADDR_W-1:0]   address;
      logic                fault;
   } rsp_type;

   typedef struct packed {
      logic [1:0]          walk_level;
      logic                walk_busy;
      logic [VA_W-1:0]     held_vaddr;
   } walk_state_type;

endpackage

`default_nettype wire

// File: rtl/four_level_page_table_walker.sv
// Top level of the four-level page table walker: input register, walk step, result register.
// An accepted item enters the input register; its result then goes to the result register.
// Throughput: one item per cycle unless stalled by rsp_ready; step: a mask, one 52-bit add.
// The input stage advances whenever the result register is empty or being taken.
// Entry items that hit an idle walker are consumed with no result.
// Synchronous active-high reset empties both registers and leaves the walker idle at level 0.
`default_nettype none

module four_level_page_table_walker (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  var flptw_pkg::req_type req_item,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output flptw_pkg::rsp_type  rsp_item
);

   logic                      in_valid_ff, in_valid_in;
   flptw_pkg::req_type        in_item_ff, in_item_in;
   logic                      out_valid_ff, out_valid_in;
   flptw_pkg::rsp_type        out_item_ff, out_item_in;
   flptw_pkg::walk_state_type state_ff, state_in;

   logic                      step_valid;
   flptw_pkg::rsp_type        step_result;
   flptw_pkg::walk_state_type step_state;
   logic                      advance;

   flptw_step u_step (
      .item         (in_item_ff),
      .state        (state_ff),
      .result_valid (step_valid),
      .result       (step_result),
      .state_next   (step_state)
   );

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      state_in     = state_ff;
      if (advance) begin
         out_valid_in = in_valid_ff && step_valid;
         if (in_valid_ff) begin
            out_item_in = step_result;
            state_in    = step_state;
         end
      end
      if (req_ready) begin
         in_valid_in = req_valid;
         in_item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   a_fault_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.fault |->
         rsp_item.result_kind == flptw_pkg::KIND_FINISH && rsp_item.address == '0)
      else $error("fault result not a finished item with zero address");

   a_idle_level: assert property (@(posedge clock) disable iff (reset)
      !state_ff.walk_busy |-> state_ff.walk_level == flptw_pkg::LEVEL_PT)
      else $error("idle walker holds a non-zero level");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> $stable(state_ff))
      else $error("walk state moved while result register stalled");

   a_finish_goes_idle: assert property (@(posedge clock) disable iff (reset)
      advance && in_valid_ff && step_valid
         && step_result.result_kind == flptw_pkg::KIND_FINISH |=> !state_ff.walk_busy)
      else $error("walker still busy after a finished item");

endmodule

`default_nettype wire

// File: rtl/flptw_step.sv
// Combinational walk step: one request item plus walk state to result and next state.
`default_nettype none

module flptw_step (
   input  var flptw_pkg::req_type        item,
   input  var flptw_pkg::walk_state_type state,
   output logic                          result_valid,
   output flptw_pkg::rsp_type            result,
   output flptw_pkg::walk_state_type     state_next
);

   logic [flptw_pkg::ENTRY_W-1:0] entry;
   logic [flptw_pkg::VA_W-1:0]    va;
   logic [flptw_pkg::ADDR_W-1:0]  frame;
   logic [flptw_pkg::ADDR_W-1:0]  root;
   logic [8:0]                    next_idx;
   logic                          present;
   logic                          page_size;

   assign entry     = item.read_data;
   assign va        = state.held_vaddr;
   assign frame     = flptw_pkg::ADDR_W'(entry & flptw_pkg::FRAME_MASK);
   assign root      = {item.table_root[flptw_pkg::ADDR_W-1:4], 4'h0};
   assign present   = entry[flptw_pkg::PRESENT_BIT];
   assign page_size = entry[flptw_pkg::PS_BIT];

   always_comb begin
      case (state.walk_level)
         flptw_pkg::LEVEL_PML4: next_idx = va[38:30];
         flptw_pkg::LEVEL_PDPT: next_idx = va[29:21];
         default:               next_idx = va[20:12];
      endcase
   end

   always_comb begin
      state_next         = state;
      result_valid       = 1'b0;
      result.result_kind = flptw_pkg::KIND_READ;
      result.address     = '0;
      result.fault       = 1'b0;
      if (item.mode == flptw_pkg::MODE_START) begin
         state_next.held_vaddr = item.vaddr;
         state_next.walk_busy  = 1'b1;
         state_next.walk_level = flptw_pkg::LEVEL_PML4;
         result_valid          = 1'b1;
         result.address = root + flptw_pkg::ADDR_W'({item.vaddr[47:39], 3'b000});
      end else if (state.walk_busy) begin
         result_valid = 1'b1;
         if (!present || (state.walk_level == flptw_pkg::LEVEL_PT && frame == '0)) begin
            state_next.walk_busy  = 1'b0;
            state_next.walk_level = flptw_pkg::LEVEL_PT;
            result.result_kind    = flptw_pkg::KIND_FINISH;
            result.fault          = 1'b1;
         end else if (state.walk_level == flptw_pkg::LEVEL_PDPT && page_size) begin
            state_next.walk_busy  = 1'b0;
            state_next.walk_level = flptw_pkg::LEVEL_PT;
            result.result_kind    = flptw_pkg::KIND_FINISH;
            result.address        = {entry[51:30], va[29:0]};
         end else if (state.walk_level == flptw_pkg::LEVEL_PD && page_size) begin
            state_next.walk_busy  = 1'b0;
            state_next.walk_level = flptw_pkg::LEVEL_PT;
            result.result_kind    = flptw_pkg::KIND_FINISH;
            result.address        = flptw_pkg::ADDR_W'(entry & flptw_pkg::FRAME_2M_MASK)
                                    | flptw_pkg::ADDR_W'(va[20:0]);
         end else if (state.walk_level == flptw_pkg::LEVEL_PT) begin
            state_next.walk_busy  = 1'b0;
            state_next.walk_level = flptw_pkg::LEVEL_PT;
            result.result_kind    = flptw_pkg::KIND_FINISH;
            result.address        = frame | flptw_pkg::ADDR_W'(va[11:0]);
         end else begin
            state_next.walk_level = state.walk_level - 2'd1;
            result.address        = frame | flptw_pkg::ADDR_W'({next_idx, 3'b000});
         end
      end
   end

endmodule

`default_nettype wire
